// File: design/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and codes for the JSON string unescaper
// Request record passed from the decoder front to the result sequencer,
// result kinds, error codes and queue sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

	// Result kinds
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// Error codes
	localparam logic [3:0] ERR_NONE         = 4'd0;
	localparam logic [3:0] ERR_NO_QUOTE     = 4'd1;
	localparam logic [3:0] ERR_CONTROL      = 4'd2;
	localparam logic [3:0] ERR_SHORT_ESC    = 4'd3;
	localparam logic [3:0] ERR_BAD_ESC      = 4'd4;
	localparam logic [3:0] ERR_SHORT_UNI    = 4'd5;
	localparam logic [3:0] ERR_BAD_HEX      = 4'd6;
	localparam logic [3:0] ERR_MISSING_LOW  = 4'd7;
	localparam logic [3:0] ERR_BAD_LOW      = 4'd8;
	localparam logic [3:0] ERR_UNPAIRED_LOW = 4'd9;
	localparam logic [3:0] ERR_UNTERMINATED = 4'd10;

	// Request queue sizing
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	// One request: the results caused by one input byte.
	// Data bytes come first, then the optional end marker or error.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      n_bytes;
		logic            tail;
		logic [1:0]      tail_kind;
		logic [3:0]      tail_code;
	} jsu_req_t;

endpackage

`default_nettype wire

// File: design/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front: escape decoder
// Takes one byte per cycle while take is high, runs the escape and surrogate
// state machine and turns each byte into a request: up to four bytes, a tail.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_front
	import jsu_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_text,
	output logic            push,
	output jsu_req_t        req
);

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [5:0] HI_SURR  = 6'b110110;
	localparam logic [5:0] LO_SURR  = 6'b110111;

	typedef enum logic [3:0] {
		M_EXPECT   = 4'd0,
		M_SKIP     = 4'd1,
		M_STR      = 4'd2,
		M_ESC      = 4'd3,
		M_HEX1     = 4'd4,
		M_NEED_BSL = 4'd5,
		M_NEED_U   = 4'd6,
		M_HEX2     = 4'd7
	} mode_t;

	mode_t       mode_q, mode_d;
	logic [11:0] hex_q, hex_d;
	logic [1:0]  cnt_q, cnt_d;
	logic [9:0]  hs_q, hs_d;

	logic        dig_ok;
	logic [3:0]  dig_val;
	logic [15:0] full_hex;
	logic [20:0] cp;
	logic [2:0]  enc_n;
	logic [3:0][7:0] enc_b;
	logic [3:0]  err;
	logic        end_mark;
	logic [2:0]  n_bytes;
	logic [3:0][7:0] bytes;

	// hex digit decode
	always_comb begin
		dig_ok  = 1'b1;
		dig_val = 4'd0;
		if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
			dig_val = 4'(in_byte - 8'h30);
		end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
			dig_val = 4'(in_byte - 8'h57);
		end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
			dig_val = 4'(in_byte - 8'h37);
		end else begin
			dig_ok = 1'b0;
		end
	end

	assign full_hex = {hex_q, dig_val};

	// code point: plain escape, or high and low surrogate combined
	assign cp = (mode_q == M_HEX2) ? {11'(hs_q) + 11'h040, full_hex[9:0]}
	                               : {5'd0, full_hex};

	// UTF-8 encode
	always_comb begin
		enc_b = '0;
		if (cp <= 21'h7F) begin
			enc_n    = 3'd1;
			enc_b[0] = cp[7:0];
		end else if (cp <= 21'h7FF) begin
			enc_n    = 3'd2;
			enc_b[0] = {3'b110, cp[10:6]};
			enc_b[1] = {2'b10, cp[5:0]};
		end else if (cp <= 21'hFFFF) begin
			enc_n    = 3'd3;
			enc_b[0] = {4'b1110, cp[15:12]};
			enc_b[1] = {2'b10, cp[11:6]};
			enc_b[2] = {2'b10, cp[5:0]};
		end else begin
			enc_n    = 3'd4;
			enc_b[0] = {5'b11110, cp[20:18]};
			enc_b[1] = {2'b10, cp[17:12]};
			enc_b[2] = {2'b10, cp[11:6]};
			enc_b[3] = {2'b10, cp[5:0]};
		end
	end

	// next state and request contents
	always_comb begin
		mode_d   = mode_q;
		hex_d    = hex_q;
		cnt_d    = cnt_q;
		hs_d     = hs_q;
		err      = ERR_NONE;
		end_mark = 1'b0;
		n_bytes  = 3'd0;
		bytes    = '0;

		case (mode_q)
			M_SKIP: begin
				if (in_byte == CH_QUOTE) mode_d = M_STR;
			end
			M_STR: begin
				if (in_byte == CH_QUOTE) begin
					end_mark = 1'b1;
					mode_d   = M_EXPECT;
				end else if (in_byte[7:5] == 3'd0) begin
					err = ERR_CONTROL;
				end else if (in_byte == CH_BSL) begin
					mode_d = M_ESC;
				end else begin
					n_bytes  = 3'd1;
					bytes[0] = in_byte;
				end
			end
			M_ESC: begin
				mode_d  = M_STR;
				n_bytes = 3'd1;
				case (in_byte)
					CH_QUOTE: bytes[0] = CH_QUOTE;
					CH_BSL:   bytes[0] = CH_BSL;
					CH_SLASH: bytes[0] = CH_SLASH;
					CH_B:     bytes[0] = 8'h08;
					CH_F:     bytes[0] = 8'h0C;
					CH_N:     bytes[0] = 8'h0A;
					CH_R:     bytes[0] = 8'h0D;
					CH_T:     bytes[0] = 8'h09;
					CH_U: begin
						n_bytes = 3'd0;
						hex_d   = '0;
						cnt_d   = '0;
						mode_d  = M_HEX1;
					end
					default: begin
						n_bytes = 3'd0;
						err     = ERR_BAD_ESC;
					end
				endcase
			end
			M_HEX1, M_HEX2: begin
				if (!dig_ok) begin
					err = ERR_BAD_HEX;
				end else begin
					hex_d = full_hex[11:0];
					if (cnt_q == 2'd3) begin
						cnt_d = '0;
						if (mode_q == M_HEX1) begin
							if (full_hex[15:10] == HI_SURR) begin
								hs_d   = full_hex[9:0];
								mode_d = M_NEED_BSL;
							end else if (full_hex[15:10] == LO_SURR) begin
								err = ERR_UNPAIRED_LOW;
							end else begin
								n_bytes = enc_n;
								bytes   = enc_b;
								mode_d  = M_STR;
							end
						end else begin
							if (full_hex[15:10] != LO_SURR) begin
								err = ERR_BAD_LOW;
							end else begin
								n_bytes = enc_n;
								bytes   = enc_b;
								mode_d  = M_STR;
							end
						end
					end else begin
						cnt_d = cnt_q + 2'd1;
					end
				end
			end
			M_NEED_BSL: begin
				if (in_byte == CH_BSL) mode_d = M_NEED_U;
				else err = ERR_MISSING_LOW;
			end
			M_NEED_U: begin
				if (in_byte == CH_U) begin
					hex_d  = '0;
					cnt_d  = '0;
					mode_d = M_HEX2;
				end else begin
					err = ERR_MISSING_LOW;
				end
			end
			default: begin
				if (in_byte == CH_QUOTE) mode_d = M_STR;
				else err = ERR_NO_QUOTE;
			end
		endcase

		// text ran out with the string still open
		if (err == ERR_NONE && end_of_text) begin
			case (mode_d)
				M_STR:              err = ERR_UNTERMINATED;
				M_ESC:              err = ERR_SHORT_ESC;
				M_HEX1, M_HEX2:     err = ERR_SHORT_UNI;
				M_NEED_BSL, M_NEED_U: err = ERR_MISSING_LOW;
				default:            err = ERR_NONE;
			endcase
		end

		if (err != ERR_NONE) begin
			mode_d = M_SKIP;
			hex_d  = '0;
			cnt_d  = '0;
		end
		if (end_of_text) mode_d = M_EXPECT;
	end

	always_comb begin
		req.bytes     = bytes;
		req.n_bytes   = n_bytes;
		req.tail      = (err != ERR_NONE) || end_mark;
		req.tail_kind = (err != ERR_NONE) ? KIND_ERROR : KIND_END;
		req.tail_code = err;
	end

	// drop requests that carry no result
	assign push = take && ((n_bytes != 3'd0) || req.tail);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_EXPECT;
			hex_q  <= '0;
			cnt_q  <= '0;
			hs_q   <= '0;
		end else if (take) begin
			mode_q <= mode_d;
			hex_q  <= hex_d;
			cnt_q  <= cnt_d;
			hs_q   <= hs_d;
		end
	end

endmodule

`default_nettype wire

// File: design/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue: request queue
// Small register queue that decouples the decoder from the result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_queue
	import jsu_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire jsu_req_t push_req,
	input  wire logic     pop,
	output jsu_req_t      head,
	output logic          empty,
	output logic          full
);

	jsu_req_t               entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]    wr_q;
	logic [QUEUE_AW-1:0]    rd_q;
	logic [QUEUE_CW-1:0]    count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign head  = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_q] <= push_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// File: design/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back: result sequencer
// Walks the head request one result per cycle, unless stalled, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_back
	import jsu_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire jsu_req_t head,
	input  wire logic     empty,
	output logic          pop,
	output logic          res_valid,
	input  wire logic     res_stall,
	output logic [7:0]    out_byte,
	output logic [1:0]    kind,
	output logic [3:0]    error_code,
	output logic          last
);

	logic [2:0] idx_q;
	logic [2:0] total;
	logic       advance;
	logic       is_last;
	logic       is_byte;

	logic       valid_q;
	logic [7:0] byte_q;
	logic [1:0] kind_q;
	logic [3:0] code_q;
	logic       last_q;

	assign total   = head.n_bytes + 3'(head.tail);
	assign is_last = (idx_q == total - 3'd1);
	assign is_byte = (idx_q < head.n_bytes);
	assign advance = !empty && (!valid_q || !res_stall);
	assign pop     = advance && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (advance) begin
				valid_q <= 1'b1;
				idx_q   <= is_last ? 3'd0 : idx_q + 3'd1;
			end else if (!res_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q <= is_byte ? head.bytes[idx_q[1:0]] : 8'd0;
			kind_q <= is_byte ? KIND_DATA : head.tail_kind;
			code_q <= is_byte ? ERR_NONE : head.tail_code;
			last_q <= is_last;
		end
	end

	assign res_valid  = valid_q;
	assign out_byte   = byte_q;
	assign kind       = kind_q;
	assign error_code = code_q;
	assign last       = last_q;

endmodule

`default_nettype wire

// File: design/json_string_unescape_top.sv
// ----------------------------------------------------------------------------
// json_string_unescape_top: streaming JSON string unescaper
// Decodes one quoted JSON string per request stream into UTF-8 bytes,
// an end marker, or a numbered error.
// ----------------------------------------------------------------------------
// The block takes one raw text byte per cycle on the source channel and can
// take a new request in every cycle while the queue has room. Each byte
// gives zero to five results: up to four decoded UTF-8 bytes followed by an
// end marker or an error. Results leave one per cycle, unless res_stall is
// high, through a registered output, so a byte that gives several results
// holds the result side until they have all left; a four-entry request
// queue between the decoder and the result sequencer absorbs these bursts,
// and the source sees stall only when that queue is full. With an empty
// queue the first result of a byte passes the queue entry and then the
// output register before it is presented. The last flag marks the final
// result caused by one input byte; bytes that cause no result (an opening
// quote, a backslash, most hex digits) leave nothing on the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_top
	import jsu_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,

	// source channel: one text byte per request
	input  wire logic       src_valid,
	output logic            src_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_text,

	// result channel
	output logic            res_valid,
	input  wire logic       res_stall,
	output logic [7:0]      out_byte,
	output logic [1:0]      kind,
	output logic [3:0]      error_code,
	output logic            last
);

	logic     take;
	logic     push;
	logic     pop;
	logic     q_empty;
	logic     q_full;
	jsu_req_t push_req;
	jsu_req_t head_req;

	// hold off the source while the queue is full
	assign src_stall = q_full;
	assign take      = src_valid && !q_full;

	// decoder: one byte in, one request out
	jsu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.push        (push),
		.req         (push_req)
	);

	// request queue between decoder and sequencer
	jsu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_req (push_req),
		.pop      (pop),
		.head     (head_req),
		.empty    (q_empty),
		.full     (q_full)
	);

	// sequencer: advance one result per cycle, unless stalled, into the output register
	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_req),
		.empty      (q_empty),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.out_byte   (out_byte),
		.kind       (kind),
		.error_code (error_code),
		.last       (last)
	);

endmodule

`default_nettype wire
